[hdl/gre_decapsulation_parser_assert.svh]
// Assertion helpers for the GRE decapsulation parser.
`ifndef GRE_DECAPSULATION_PARSER_ASSERT_SVH
`define GRE_DECAPSULATION_PARSER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define GDP_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gdp assertion failed");

// Next-cycle implication, checked during reset as well.
`define GDP_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gdp assertion failed");

`endif

[hdl/gdp_pkg.sv]
`default_nettype none

package gdp_pkg;

    localparam logic [5:0]  IP_HDR_MIN         = 6'd20;
    localparam logic [4:0]  GRE_HDR_MIN        = 5'd4;
    localparam logic [4:0]  GRE_OPT_BYTES      = 5'd4;
    localparam logic [15:0] PAYLOAD_TYPE_RESET = 16'h0800;
    localparam logic [15:0] COUNT_MAX          = 16'hFFFF;
    localparam int          QUEUE_DEPTH        = 4;

    // Bit positions in the GRE flags word
    localparam int FLAG_C_BIT = 15;
    localparam int FLAG_R_BIT = 14;
    localparam int FLAG_K_BIT = 13;
    localparam int FLAG_S_BIT = 12;

    localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
    localparam logic [2:0] VERDICT_SHORT     = 3'd1;
    localparam logic [2:0] VERDICT_BAD_CSUM  = 3'd2;
    localparam logic [2:0] VERDICT_ROUTING   = 3'd3;
    localparam logic [2:0] VERDICT_BAD_TYPE  = 3'd4;

    // One classified byte, handed from the parser to the result stage
    typedef struct packed {
        logic [7:0]  data;
        logic        emit;
        logic [7:0]  port;
        logic        last;
        logic        too_short;
        logic        csum_on;
        logic [15:0] sum;
        logic [7:0]  hold;
        logic        odd_len;
        logic [2:0]  drop;
    } gdp_job_t;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

[hdl/gdp_fifo.sv]
`default_nettype none

module gdp_fifo
    import gdp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire gdp_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          empty,
    output gdp_job_t      pop_job
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gdp_job_t           entry_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[hdl/gdp_front.sv]
`default_nettype none

module gdp_front
    import gdp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        accept,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_packet,
    input  wire logic [7:0]  arrival_port,
    output logic             push,
    output gdp_job_t         job
);

    logic [15:0] payload_type_reg;
    logic [15:0] count_reg,   count_next;
    logic [5:0]  ihl_reg,     ihl_next;
    logic [15:0] dlen_reg,    dlen_next;
    logic [15:0] flags_reg,   flags_next;
    logic [15:0] itype_reg,   itype_next;
    logic [4:0]  greh_reg,    greh_next;
    logic [15:0] sum_reg,     sum_next;
    logic [7:0]  hold_reg,    hold_next;
    logic [2:0]  drop_reg,    drop_next;

    logic        hdr_ok;
    logic        in_gre;
    logic        emit;
    logic [15:0] gre_idx;
    logic [15:0] count_inc;
    logic        too_short;

    always_comb begin
        ihl_next   = ihl_reg;
        dlen_next  = dlen_reg;
        flags_next = flags_reg;
        itype_next = itype_reg;
        greh_next  = greh_reg;
        sum_next   = sum_reg;
        hold_next  = hold_reg;
        drop_next  = drop_reg;
        emit       = 1'b0;

        // IP header: length nibble and total length
        if (count_reg == 16'd0) begin
            ihl_next = {data_byte[3:0], 2'b00};
        end else if (count_reg == 16'd2) begin
            dlen_next = {data_byte, dlen_reg[7:0]};
        end else if (count_reg == 16'd3) begin
            dlen_next = {dlen_reg[15:8], data_byte};
        end
        hdr_ok = (ihl_next >= IP_HDR_MIN);
        if (count_reg == 16'd0 && !hdr_ok) begin
            drop_next = VERDICT_SHORT;
        end

        in_gre  = hdr_ok && (count_reg != COUNT_MAX)
                  && (count_reg >= {10'd0, ihl_next}) && (count_reg < dlen_next);
        gre_idx = count_reg - {10'd0, ihl_next};

        if (in_gre) begin
            if (!gre_idx[0]) begin
                hold_next = data_byte;
            end else begin
                sum_next = ones_add(sum_reg, {hold_reg, data_byte});
            end
            if (gre_idx == 16'd0) begin
                flags_next = {data_byte, 8'h00};
            end else if (gre_idx == 16'd1) begin
                flags_next = {flags_reg[15:8], data_byte};
                greh_next  = GRE_HDR_MIN
                             + (flags_reg[FLAG_C_BIT] ? GRE_OPT_BYTES : 5'd0)
                             + (flags_reg[FLAG_K_BIT] ? GRE_OPT_BYTES : 5'd0)
                             + (flags_reg[FLAG_S_BIT] ? GRE_OPT_BYTES : 5'd0);
                if (flags_reg[FLAG_R_BIT] && drop_reg == VERDICT_ACCEPT) begin
                    drop_next = VERDICT_ROUTING;
                end
            end else if (gre_idx == 16'd2) begin
                itype_next = {data_byte, 8'h00};
            end else if (gre_idx == 16'd3) begin
                itype_next = {itype_reg[15:8], data_byte};
                if (itype_next != payload_type_reg && drop_reg == VERDICT_ACCEPT) begin
                    drop_next = VERDICT_BAD_TYPE;
                end
            end else if (gre_idx >= {11'd0, greh_reg} && drop_reg == VERDICT_ACCEPT) begin
                emit = 1'b1;
            end
        end

        count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;
        count_next = end_of_packet ? 16'd0 : count_inc;

        too_short = (count_inc < 16'd4) || !hdr_ok || (count_inc < dlen_next)
                    || ({1'b0, dlen_next} < ({11'd0, ihl_next} + 17'(GRE_HDR_MIN)));

        job.data      = emit ? data_byte : 8'h00;
        job.emit      = emit;
        job.port      = arrival_port;
        job.last      = end_of_packet;
        job.too_short = too_short;
        job.csum_on   = flags_next[FLAG_C_BIT];
        job.sum       = sum_next;
        job.hold      = hold_next;
        job.odd_len   = dlen_next[0] ^ ihl_next[0];
        job.drop      = drop_next;
    end

    assign push = accept && (emit || end_of_packet);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_type_reg <= PAYLOAD_TYPE_RESET;
        end else if (cfg_wr_en) begin
            payload_type_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && end_of_packet)) begin
            count_reg <= '0;
            ihl_reg   <= '0;
            dlen_reg  <= '0;
            flags_reg <= '0;
            itype_reg <= '0;
            greh_reg  <= GRE_HDR_MIN;
            sum_reg   <= '0;
            hold_reg  <= '0;
            drop_reg  <= VERDICT_ACCEPT;
        end else if (accept) begin
            count_reg <= count_next;
            ihl_reg   <= ihl_next;
            dlen_reg  <= dlen_next;
            flags_reg <= flags_next;
            itype_reg <= itype_next;
            greh_reg  <= greh_next;
            sum_reg   <= sum_next;
            hold_reg  <= hold_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

`default_nettype wire

[hdl/gdp_back.sv]
`default_nettype none

module gdp_back
    import gdp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     job_avail,
    input  wire gdp_job_t job,
    output logic          pop,
    output logic          m_valid,
    input  wire logic     m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_byte_valid,
    output logic [7:0]    m_out_port,
    output logic          m_packet_done,
    output logic [2:0]    m_verdict
);

    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        bvalid_reg;
    logic [7:0]  port_reg;
    logic        done_reg;
    logic [2:0]  verdict_reg, verdict_next;
    logic [15:0] folded;

    // Fold a trailing odd byte into the checksum, then rank the verdict
    always_comb begin
        folded = job.odd_len ? ones_add(job.sum, {job.hold, 8'h00}) : job.sum;
        if (!job.last) begin
            verdict_next = VERDICT_ACCEPT;
        end else if (job.too_short) begin
            verdict_next = VERDICT_SHORT;
        end else if (job.csum_on && folded != 16'hFFFF) begin
            verdict_next = VERDICT_BAD_CSUM;
        end else if (job.drop == VERDICT_ROUTING) begin
            verdict_next = VERDICT_ROUTING;
        end else if (job.drop == VERDICT_BAD_TYPE) begin
            verdict_next = VERDICT_BAD_TYPE;
        end else begin
            verdict_next = VERDICT_ACCEPT;
        end
    end

    assign pop = job_avail && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            byte_reg    <= job.data;
            bvalid_reg  <= job.emit;
            port_reg    <= job.port;
            done_reg    <= job.last;
            verdict_reg <= verdict_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_byte_valid  = bvalid_reg;
    assign m_out_port    = port_reg;
    assign m_packet_done = done_reg;
    assign m_verdict     = verdict_reg;

endmodule

`default_nettype wire

[hdl/gre_decapsulation_parser.sv]
// GRE decapsulation parser.
// Input channel (s_valid/s_ready): one IPv4 datagram byte per item, first byte first,
// with s_end_of_packet on the last byte and the arrival port on every byte.
// Result channel (m_valid/m_ready): one item per passed payload byte
// (m_byte_valid set) and one item per last input byte (m_packet_done set, m_verdict
// valid: accepted, too short, bad checksum, routing present, wrong payload type).
// Input bytes that are neither payload nor last produce no item.
// cfg_wr_en/cfg_wr_data write the expected payload protocol type; write it only
// while no packet is in flight.
// Throughput: one byte per cycle while the queue has room; s_ready is low when full.
// When the queue and output register are empty, an accepted byte's result is written
// into the queue and then into the output register, which drives m_valid.
// A queue of FIFO_DEPTH results sits between parser and output register; when the
// receiver stalls it fills, then s_ready drops until m_ready returns.
// Reset (aresetn low at a clock edge) clears the parser, the queue and the output
// register and restores the payload type to 0x0800.

`default_nettype none

`include "gre_decapsulation_parser_assert.svh"

module gre_decapsulation_parser
    import gdp_pkg::*;
#(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_packet,
    input  wire logic [7:0]  s_arrival_port,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic [7:0]       m_out_port,
    output logic             m_packet_done,
    output logic [2:0]       m_verdict
);

    logic     accept;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    gdp_job_t push_job;
    gdp_job_t pop_job;

    // Take a byte whenever the queue has room
    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    // Parse headers, track the checksum, classify each byte
    gdp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .accept        (accept),
        .data_byte     (s_data_byte),
        .end_of_packet (s_end_of_packet),
        .arrival_port  (s_arrival_port),
        .push          (push),
        .job           (push_job)
    );

    // Hold classified items while the receiver stalls
    gdp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .pop_job  (pop_job)
    );

    // Finish the verdict and drive the output register
    gdp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_avail     (!empty),
        .job           (pop_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_out_port    (m_out_port),
        .m_packet_done (m_packet_done),
        .m_verdict     (m_verdict)
    );

    // Every result carries a byte or a verdict
    `GDP_ASSERT_IMPLY(a_result_has_content, aclk, aresetn, m_valid, m_byte_valid || m_packet_done)
    // Only a last-byte result carries a nonzero verdict
    `GDP_ASSERT_IMPLY(a_verdict_only_at_end, aclk, aresetn, m_valid && !m_packet_done, m_verdict == VERDICT_ACCEPT)
    // Verdict stays within the defined codes
    `GDP_ASSERT_IMPLY(a_verdict_range, aclk, aresetn, m_valid, m_verdict <= VERDICT_BAD_TYPE)
    // Reset empties the output and opens the input
    `GDP_ASSERT_NEXT(a_reset_clears, aclk, !aresetn, !m_valid && s_ready)

endmodule

`default_nettype wire
